/* sv/assert_macros.svh */
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define LFU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lfu_cache_table check failed");

// Checked at every rising clock edge, reset included.
`define LFU_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("lfu_cache_table check failed");

`endif

/* sv/lfu_ct_pkg.sv */
package lfu_ct_pkg;

  localparam int unsigned NumEntries = 16;
  localparam int unsigned IdxW       = $clog2(NumEntries);
  localparam int unsigned OccW       = $clog2(NumEntries + 1);
  localparam int unsigned KeyW       = 16;
  localparam int unsigned ValW       = 31;
  localparam int unsigned CntW       = 16;
  localparam int unsigned RankW      = IdxW;
  localparam int unsigned CapW       = 5;

  localparam logic [CapW-1:0] CapReset = CapW'(NumEntries);
  localparam logic [CntW-1:0] CntMax   = '1;

  localparam logic FuncGet = 1'b0;
  localparam logic FuncPut = 1'b1;

  typedef struct packed {
    logic            func;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } lfu_ct_in_t;

  typedef struct packed {
    logic            hit;
    logic [ValW-1:0] read_value;
  } lfu_ct_out_t;

  // One table entry as seen at the read port.
  typedef struct packed {
    logic             valid;
    logic [KeyW-1:0]  key;
    logic [ValW-1:0]  data;
    logic [CntW-1:0]  count;
    logic [RankW-1:0] rank;
  } entry_t;

  typedef enum logic [1:0] {
    UpdNone,
    UpdTouch,
    UpdInsert
  } upd_op_e;

  // Table update issued by the sequencer in its final cycle.
  typedef struct packed {
    upd_op_e          op;
    logic [IdxW-1:0]  slot;
    logic             data_we;
    logic [KeyW-1:0]  key;
    logic [ValW-1:0]  data;
    logic [CntW-1:0]  count;
    logic [RankW-1:0] rank_ref;
    logic             evict;
    logic [RankW-1:0] victim_rank;
  } upd_t;

  // Summary gathered by the scan over all entries.
  typedef struct packed {
    logic             match_found;
    logic [IdxW-1:0]  match_idx;
    logic [ValW-1:0]  match_data;
    logic [CntW-1:0]  match_cnt;
    logic [RankW-1:0] match_rank;
    logic             free_found;
    logic [IdxW-1:0]  free_idx;
    logic             vict_found;
    logic [IdxW-1:0]  vict_idx;
    logic [RankW-1:0] vict_rank;
    logic [OccW-1:0]  occ;
  } scan_res_t;

endpackage

/* sv/lfu_ct_store.sv */
module lfu_ct_store (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [lfu_ct_pkg::IdxW-1:0]        rd_idx_i,
  output lfu_ct_pkg::entry_t                 rd_entry_o,
  input  lfu_ct_pkg::upd_t                   upd_i
);

  logic [lfu_ct_pkg::NumEntries-1:0] valid_q;
  logic [lfu_ct_pkg::KeyW-1:0]       key_q   [lfu_ct_pkg::NumEntries];
  logic [lfu_ct_pkg::ValW-1:0]       data_q  [lfu_ct_pkg::NumEntries];
  logic [lfu_ct_pkg::CntW-1:0]       count_q [lfu_ct_pkg::NumEntries];
  logic [lfu_ct_pkg::RankW-1:0]      rank_q  [lfu_ct_pkg::NumEntries];

  assign rd_entry_o.valid = valid_q[rd_idx_i];
  assign rd_entry_o.key   = key_q[rd_idx_i];
  assign rd_entry_o.data  = data_q[rd_idx_i];
  assign rd_entry_o.count = count_q[rd_idx_i];
  assign rd_entry_o.rank  = rank_q[rd_idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (upd_i.op == lfu_ct_pkg::UpdInsert) begin
      valid_q[upd_i.slot] <= 1'b1;
    end
  end

  // Each lane updates its own rank; key, data and count are written at one slot.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < lfu_ct_pkg::NumEntries; i++) begin
      if (upd_i.slot == lfu_ct_pkg::IdxW'(i)) begin
        if (upd_i.op == lfu_ct_pkg::UpdTouch) begin
          count_q[i] <= upd_i.count;
          rank_q[i]  <= '0;
          if (upd_i.data_we) begin
            data_q[i] <= upd_i.data;
          end
        end else if (upd_i.op == lfu_ct_pkg::UpdInsert) begin
          key_q[i]   <= upd_i.key;
          data_q[i]  <= upd_i.data;
          count_q[i] <= upd_i.count;
          rank_q[i]  <= '0;
        end
      end else if (valid_q[i]) begin
        if (upd_i.op == lfu_ct_pkg::UpdTouch) begin
          if (rank_q[i] < upd_i.rank_ref) begin
            rank_q[i] <= rank_q[i] + 1'b1;
          end
        end else if (upd_i.op == lfu_ct_pkg::UpdInsert) begin
          // Entries older than an evicted one close the gap and then age by one.
          if (!(upd_i.evict && (rank_q[i] > upd_i.victim_rank))) begin
            rank_q[i] <= rank_q[i] + 1'b1;
          end
        end
      end
    end
  end

endmodule

/* sv/lfu_ct_scan.sv */
module lfu_ct_scan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clear_i,
  input  logic                          step_i,
  input  logic [lfu_ct_pkg::IdxW-1:0]   idx_i,
  input  lfu_ct_pkg::entry_t            entry_i,
  input  logic [lfu_ct_pkg::KeyW-1:0]   key_i,
  output lfu_ct_pkg::scan_res_t         res_o
);

  lfu_ct_pkg::scan_res_t        res_q;
  logic [lfu_ct_pkg::CntW-1:0]  vict_cnt_q;
  logic                         is_match;
  logic                         is_victim;

  // The one compare unit: key match and victim ordering for the current entry.
  assign is_match  = entry_i.valid && !res_q.match_found && (entry_i.key == key_i);
  assign is_victim = entry_i.valid &&
                     (!res_q.vict_found || (entry_i.count < vict_cnt_q) ||
                      ((entry_i.count == vict_cnt_q) && (entry_i.rank > res_q.vict_rank)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q      <= '0;
      vict_cnt_q <= '0;
    end else if (clear_i) begin
      res_q.match_found <= 1'b0;
      res_q.free_found  <= 1'b0;
      res_q.vict_found  <= 1'b0;
      res_q.occ         <= '0;
    end else if (step_i) begin
      if (entry_i.valid) begin
        res_q.occ <= res_q.occ + 1'b1;
      end
      if (is_match) begin
        res_q.match_found <= 1'b1;
        res_q.match_idx   <= idx_i;
        res_q.match_data  <= entry_i.data;
        res_q.match_cnt   <= entry_i.count;
        res_q.match_rank  <= entry_i.rank;
      end
      if (is_victim) begin
        res_q.vict_found <= 1'b1;
        res_q.vict_idx   <= idx_i;
        res_q.vict_rank  <= entry_i.rank;
        vict_cnt_q       <= entry_i.count;
      end
      if (!entry_i.valid && !res_q.free_found) begin
        res_q.free_found <= 1'b1;
        res_q.free_idx   <= idx_i;
      end
    end
  end

  assign res_o = res_q;

endmodule

/* sv/lfu_cache_table_core.sv */
// Channel   Direction  Handshake           Payload
// in        input      in_valid_i/stall_o  lfu_ct_in_t   (func, key, value)
// out       output     out_valid_o/stall_i lfu_ct_out_t  (hit, read_value)
// cfg       input      cfg_valid_i/ready_o capacity_in_use, 5 bits
//
// Each item goes through the transfer, a scan that walks the entries one per
// cycle through a single key and victim compare unit, and the update step.
// The input stays stalled from the transfer until the update.
// The update waits while an earlier result is still held and stalled at the
// output. Reset clears all valid bits at once, so no clearing pass is needed,
// and sets the capacity register to 16. The capacity is written only while idle.
module lfu_cache_table_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  lfu_ct_pkg::lfu_ct_in_t           in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output lfu_ct_pkg::lfu_ct_out_t          out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lfu_ct_pkg::CapW-1:0]      cfg_data_i
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StUpdate
  } state_e;

  state_e                          state_q, state_d;
  logic [lfu_ct_pkg::IdxW-1:0]     idx_q, idx_d;
  logic [lfu_ct_pkg::CapW-1:0]     cap_q, cap_d;
  lfu_ct_pkg::lfu_ct_in_t          item_q, item_d;
  logic                            out_valid_q, out_valid_d;
  lfu_ct_pkg::lfu_ct_out_t         out_data_q, out_data_d;

  lfu_ct_pkg::entry_t              entry;
  lfu_ct_pkg::scan_res_t           scan_res;
  lfu_ct_pkg::upd_t                upd;
  lfu_ct_pkg::lfu_ct_out_t         result;
  logic                            in_xfer;
  logic                            out_free;
  logic                            do_update;
  logic                            evict;
  logic [lfu_ct_pkg::OccW-1:0]     cap_eff;

  assign in_stall_o  = (state_q != StIdle);
  assign in_xfer     = in_valid_i && !in_stall_o;
  // The capacity only changes between items, never under an item in progress.
  assign cfg_ready_o = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The output register is free when empty or when its result leaves this cycle.
  assign out_free  = !out_valid_q || !out_stall_i;
  assign do_update = (state_q == StUpdate) && out_free;

  lfu_ct_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (idx_q),
    .rd_entry_o (entry),
    .upd_i      (upd)
  );

  lfu_ct_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (in_xfer),
    .step_i  (state_q == StScan),
    .idx_i   (idx_q),
    .entry_i (entry),
    .key_i   (item_q.key),
    .res_o   (scan_res)
  );

  // A capacity of zero behaves as one, and anything above the table size as the
  // table size.
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = lfu_ct_pkg::OccW'(1);
    end else if (lfu_ct_pkg::OccW'(cap_q) > lfu_ct_pkg::OccW'(lfu_ct_pkg::NumEntries)) begin
      cap_eff = lfu_ct_pkg::OccW'(lfu_ct_pkg::NumEntries);
    end else begin
      cap_eff = lfu_ct_pkg::OccW'(cap_q);
    end
  end

  assign evict = (scan_res.occ >= cap_eff) && scan_res.vict_found;

  // Build the table update from the scan summary. A hit touches the matched
  // entry; a put of a new key inserts, into the victim's slot when the table is
  // at capacity and otherwise into the lowest free slot.
  always_comb begin
    upd             = '0;
    upd.op          = lfu_ct_pkg::UpdNone;
    upd.key         = item_q.key;
    upd.data        = item_q.value;
    upd.rank_ref    = scan_res.match_rank;
    upd.evict       = evict;
    upd.victim_rank = scan_res.vict_rank;
    if (scan_res.match_found) begin
      upd.slot    = scan_res.match_idx;
      upd.data_we = (item_q.func == lfu_ct_pkg::FuncPut);
      upd.count   = (scan_res.match_cnt == lfu_ct_pkg::CntMax) ?
                    lfu_ct_pkg::CntMax : scan_res.match_cnt + 1'b1;
      if (do_update) begin
        upd.op = lfu_ct_pkg::UpdTouch;
      end
    end else if (item_q.func == lfu_ct_pkg::FuncPut) begin
      upd.slot  = evict ? scan_res.vict_idx : scan_res.free_idx;
      upd.count = lfu_ct_pkg::CntW'(1);
      if (do_update && (evict || scan_res.free_found)) begin
        upd.op = lfu_ct_pkg::UpdInsert;
      end
    end
  end

  // Read data goes out only on a get that hits.
  always_comb begin
    result.hit        = scan_res.match_found;
    result.read_value = '0;
    if (scan_res.match_found && (item_q.func == lfu_ct_pkg::FuncGet)) begin
      result.read_value = scan_res.match_data;
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cap_d       = cap_q;
    item_d      = item_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (cfg_valid_i && cfg_ready_o) begin
      cap_d = cfg_data_i;
    end
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          item_d  = in_data_i;
          idx_d   = '0;
          state_d = StScan;
        end
      end
      StScan: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == lfu_ct_pkg::IdxW'(lfu_ct_pkg::NumEntries - 1)) begin
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        if (do_update) begin
          out_valid_d = 1'b1;
          out_data_d  = result;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      cap_q       <= lfu_ct_pkg::CapReset;
      out_valid_q <= 1'b0;
      item_q      <= '0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
      item_q      <= item_d;
      out_data_q  <= out_data_d;
    end
  end

endmodule

/* sv/lfu_ct_checker.sv */
`include "assert_macros.svh"

module lfu_ct_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_o,
  input  lfu_ct_pkg::lfu_ct_in_t           in_data_i,
  input  logic                             out_valid_o,
  input  logic                             out_stall_i,
  input  lfu_ct_pkg::lfu_ct_out_t          out_data_o,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_o,
  input  logic [lfu_ct_pkg::CapW-1:0]      cfg_data_i
);

  // A result held back by the receiver stays offered and unchanged.
  `LFU_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o)
  `LFU_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(out_data_o))

  // The block works on one item at a time, so a transfer stalls the input.
  `LFU_ASSERT(a_busy_after_xfer, in_valid_i && !in_stall_o |=> in_stall_o)

  // A result without a hit never carries read data.
  `LFU_ASSERT(a_miss_zero, out_valid_o && !out_data_o.hit |-> out_data_o.read_value == '0)

  // An edge under reset leaves no result pending at the next edge.
  `LFU_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o)

endmodule

bind lfu_cache_table_core lfu_ct_checker u_lfu_ct_checker (.*);

/* tb/sv/tb_lfu_cache_table_core.sv */
`timescale 1ns / 100ps

module tb_lfu_cache_table_core;

  // Self-checking bench. Every accepted input transfer is run through a
  // predictor of the table at the edge where it is accepted; the predicted
  // result is queued and the result sink compares each output transfer with
  // the oldest entry of that queue. A directed table comes first, then random
  // phases at several capacity settings, with keys mostly from a small pool
  // per phase so that hits, updates and evictions are frequent.

  localparam int unsigned CycleLimit = 4_000_000;
  localparam int unsigned PoolMax    = 32;

  typedef enum logic {
    RowItem,
    RowCfg
  } row_kind_e;

  // One line of the directed table. A configuration line carries the new
  // capacity in its value field. Where "typed" is set, the expected result
  // is the one written in the line, not the predicted one.
  typedef struct packed {
    row_kind_e                   kind;
    logic                        func;
    logic [lfu_ct_pkg::KeyW-1:0] key;
    logic [lfu_ct_pkg::ValW-1:0] value;
    logic                        typed;
    logic                        hit;
    logic [lfu_ct_pkg::ValW-1:0] rv;
  } dir_row_t;

  // Clock and reset.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #2 clk = ~clk;

  // Block inputs. All are known from time zero.
  logic                        in_valid  = 1'b0;
  lfu_ct_pkg::lfu_ct_in_t      in_data   = '0;
  logic                        out_stall = 1'b0;
  logic                        cfg_valid = 1'b0;
  logic [lfu_ct_pkg::CapW-1:0] cfg_data  = '0;

  // Block outputs.
  logic                    in_stall;
  logic                    out_valid;
  lfu_ct_pkg::lfu_ct_out_t out_data;
  logic                    cfg_ready;

  // Predictor state: the table as it must look after every accepted transfer.
  bit                          tbl_valid [lfu_ct_pkg::NumEntries];
  logic [lfu_ct_pkg::KeyW-1:0] tbl_key   [lfu_ct_pkg::NumEntries];
  logic [lfu_ct_pkg::ValW-1:0] tbl_data  [lfu_ct_pkg::NumEntries];
  logic [lfu_ct_pkg::CntW-1:0] tbl_count [lfu_ct_pkg::NumEntries];
  int                          tbl_rank  [lfu_ct_pkg::NumEntries];
  logic [lfu_ct_pkg::CapW-1:0] cap_reg = lfu_ct_pkg::CapReset;

  // Results still owed by the block, oldest first.
  lfu_ct_pkg::lfu_ct_out_t lookup_results_q [$];

  int unsigned mismatches       = 0;
  int unsigned cycle_count      = 0;
  int          sink_hold_cycles = 0;
  bit          no_idle          = 1'b0;

  // Directed table. Results that follow directly from the transfer history
  // are typed in; the rest come from the predictor.
  dir_row_t dir_rows [0:23] = '{
    // Lookups in the empty table, at both key extremes.
    '{RowItem, lfu_ct_pkg::FuncGet, 16'h0000, 31'h00000000, 1'b1, 1'b0, 31'h00000000},
    '{RowItem, lfu_ct_pkg::FuncGet, 16'hFFFF, 31'h00000000, 1'b1, 1'b0, 31'h00000000},
    // Insert and read back the largest key and value.
    '{RowItem, lfu_ct_pkg::FuncPut, 16'hFFFF, 31'h7FFFFFFF, 1'b1, 1'b0, 31'h00000000},
    '{RowItem, lfu_ct_pkg::FuncGet, 16'hFFFF, 31'h00000000, 1'b1, 1'b1, 31'h7FFFFFFF},
    // Insert and read back the smallest key and value.
    '{RowItem, lfu_ct_pkg::FuncPut, 16'h0000, 31'h00000000, 1'b1, 1'b0, 31'h00000000},
    '{RowItem, lfu_ct_pkg::FuncGet, 16'h0000, 31'h00000000, 1'b1, 1'b1, 31'h00000000},
    // A put to a present key hits, returns zero and rewrites the value.
    '{RowItem, lfu_ct_pkg::FuncPut, 16'hFFFF, 31'h2AAAAAAA, 1'b1, 1'b1, 31'h00000000},
    '{RowItem, lfu_ct_pkg::FuncGet, 16'hFFFF, 31'h00000000, 1'b1, 1'b1, 31'h2AAAAAAA},
    '{RowItem, lfu_ct_pkg::FuncPut, 16'h5555, 31'h55555555, 1'b1, 1'b0, 31'h00000000},
    '{RowItem, lfu_ct_pkg::FuncPut, 16'hAAAA, 31'h2AAAAAAA, 1'b1, 1'b0, 31'h00000000},
    '{RowItem, lfu_ct_pkg::FuncGet, 16'hAAAA, 31'h00000000, 1'b1, 1'b1, 31'h2AAAAAAA},
    // The value field of a get is ignored.
    '{RowItem, lfu_ct_pkg::FuncGet, 16'h1234, 31'h7FFFFFFF, 1'b1, 1'b0, 31'h00000000},
    // Capacity below the occupancy: one eviction per new key, no more.
    '{RowCfg,  lfu_ct_pkg::FuncGet, 16'h0000, 31'd3,        1'b0, 1'b0, 31'h00000000},
    '{RowItem, lfu_ct_pkg::FuncPut, 16'h0F0F, 31'h00000001, 1'b1, 1'b0, 31'h00000000},
    '{RowItem, lfu_ct_pkg::FuncGet, 16'h5555, 31'h00000000, 1'b0, 1'b0, 31'h00000000},
    '{RowItem, lfu_ct_pkg::FuncGet, 16'h0000, 31'h00000000, 1'b0, 1'b0, 31'h00000000},
    // A capacity of zero behaves as one.
    '{RowCfg,  lfu_ct_pkg::FuncGet, 16'h0000, 31'd0,        1'b0, 1'b0, 31'h00000000},
    '{RowItem, lfu_ct_pkg::FuncPut, 16'h00FF, 31'h7FFFFFFF, 1'b1, 1'b0, 31'h00000000},
    '{RowItem, lfu_ct_pkg::FuncGet, 16'h0F0F, 31'h00000000, 1'b0, 1'b0, 31'h00000000},
    // A capacity above the table size behaves as the table size.
    '{RowCfg,  lfu_ct_pkg::FuncGet, 16'h0000, 31'd31,       1'b0, 1'b0, 31'h00000000},
    '{RowItem, lfu_ct_pkg::FuncPut, 16'hFF00, 31'h00000003, 1'b1, 1'b0, 31'h00000000},
    '{RowItem, lfu_ct_pkg::FuncGet, 16'hFF00, 31'h00000000, 1'b0, 1'b0, 31'h00000000},
    '{RowCfg,  lfu_ct_pkg::FuncGet, 16'h0000, 31'd16,       1'b0, 1'b0, 31'h00000000},
    '{RowItem, lfu_ct_pkg::FuncGet, 16'h00FF, 31'h00000000, 1'b0, 1'b0, 31'h00000000}
  };

  lfu_cache_table_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  // A capacity of zero acts as one, and anything above the table size acts
  // as the table size.
  function automatic int effective_capacity();
    if (cap_reg == 0) return 1;
    if (cap_reg > lfu_ct_pkg::NumEntries) return lfu_ct_pkg::NumEntries;
    return cap_reg;
  endfunction

  // Idle cycles before the next transfer on either side. During a quiet
  // stretch both sides run back to back.
  function automatic int pick_gap();
    return no_idle ? 0 : $urandom_range(0, 17);
  endfunction

  // Applies one accepted transfer to the predicted table and returns the
  // result the block must produce for it.
  function automatic lfu_ct_pkg::lfu_ct_out_t predict_access(input lfu_ct_pkg::lfu_ct_in_t it);
    lfu_ct_pkg::lfu_ct_out_t res;
    int hit_slot;
    int free_slot;
    int victim;
    int occupied;
    int ref_rank;
    res       = '0;
    hit_slot  = -1;
    free_slot = -1;
    victim    = -1;
    occupied  = 0;
    // Full scan: first key match, lowest free slot, and the victim, which
    // is the lowest count and, among equal counts, the oldest entry.
    for (int i = 0; i < lfu_ct_pkg::NumEntries; i++) begin
      if (tbl_valid[i]) begin
        occupied++;
        if (hit_slot < 0 && tbl_key[i] == it.key) hit_slot = i;
        if (victim < 0 || tbl_count[i] < tbl_count[victim] ||
            (tbl_count[i] == tbl_count[victim] && tbl_rank[i] > tbl_rank[victim]))
          victim = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit_slot >= 0) begin
      res.hit = 1'b1;
      if (it.func == lfu_ct_pkg::FuncGet) res.read_value = tbl_data[hit_slot];
      else tbl_data[hit_slot] = it.value;
      if (tbl_count[hit_slot] != lfu_ct_pkg::CntMax) tbl_count[hit_slot]++;
      // Move the entry to the front; everything that was newer ages by one.
      ref_rank = tbl_rank[hit_slot];
      for (int i = 0; i < lfu_ct_pkg::NumEntries; i++)
        if (tbl_valid[i] && i != hit_slot && tbl_rank[i] < ref_rank) tbl_rank[i]++;
      tbl_rank[hit_slot] = 0;
    end else if (it.func == lfu_ct_pkg::FuncPut) begin
      if (occupied >= effective_capacity() && victim >= 0) begin
        // Evict and close the gap in the recency order.
        ref_rank          = tbl_rank[victim];
        tbl_valid[victim] = 1'b0;
        for (int i = 0; i < lfu_ct_pkg::NumEntries; i++)
          if (tbl_valid[i] && tbl_rank[i] > ref_rank) tbl_rank[i]--;
        free_slot = victim;
      end
      if (free_slot >= 0) begin
        for (int i = 0; i < lfu_ct_pkg::NumEntries; i++)
          if (tbl_valid[i]) tbl_rank[i]++;
        tbl_valid[free_slot] = 1'b1;
        tbl_key[free_slot]   = it.key;
        tbl_data[free_slot]  = it.value;
        tbl_count[free_slot] = 1;
        tbl_rank[free_slot]  = 0;
      end
    end
    return res;
  endfunction

  // Offers one input transfer after the given number of idle cycles. The
  // task returns at the accepting edge with valid still high, so that a
  // following transfer can go out back to back.
  task automatic offer(input lfu_ct_pkg::lfu_ct_in_t it, input int gap, input bit typed,
                       input lfu_ct_pkg::lfu_ct_out_t typed_res);
    lfu_ct_pkg::lfu_ct_out_t res;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall);
    res = predict_access(it);
    lookup_results_q.push_back(typed ? typed_res : res);
  endtask

  // Takes valid down before the sender pauses.
  task automatic drop_valid();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Waits until every owed result has arrived, then gives the block the
  // length of one transfer to come back to idle.
  task automatic settle();
    drop_valid();
    while (lookup_results_q.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [lfu_ct_pkg::CapW-1:0] cap);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = cap;
    do @(posedge clk); while (!cfg_ready);
    cap_reg = cap;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // One random phase at the current capacity. Keys mostly come from a pool
  // a little larger than the capacity. Halfway through, the sender pauses
  // until the block has delivered every owed result. When hold_at is not
  // negative, the result sink is told to hold off for a long stretch at that
  // transfer while the sender keeps offering.
  task automatic run_random(input int count, input int hold_at);
    logic [lfu_ct_pkg::KeyW-1:0] keys [PoolMax];
    lfu_ct_pkg::lfu_ct_in_t      it;
    int                          pool_size;
    pool_size = effective_capacity() + $urandom_range(1, 8);
    for (int i = 0; i < pool_size; i++) keys[i] = $urandom_range(0, 65535);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 49) == 0) no_idle = !no_idle;
      if (k == hold_at) sink_hold_cycles = 300;
      if (k == count / 2) begin
        drop_valid();
        while (lookup_results_q.size() != 0) @(posedge clk);
      end
      it.func  = ($urandom_range(0, 1) == 0) ? lfu_ct_pkg::FuncGet : lfu_ct_pkg::FuncPut;
      it.key   = ($urandom_range(0, 9) == 0) ?
                 lfu_ct_pkg::KeyW'($urandom_range(0, 65535)) :
                 keys[$urandom_range(0, pool_size - 1)];
      it.value = lfu_ct_pkg::ValW'($urandom);
      offer(it, pick_gap(), 1'b0, '0);
    end
    no_idle = 1'b0;
  endtask

  // Stimulus and the end of the run.
  initial begin : stimulus
    lfu_ct_pkg::lfu_ct_in_t      it;
    lfu_ct_pkg::lfu_ct_out_t     want;
    logic [lfu_ct_pkg::CapW-1:0] phase_caps  [8];
    int                          phase_items [8];
    phase_caps  = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd2, 5'd16, 5'd16};
    phase_items = '{400, 150, 250, 150, 200, 150, 250, 350};
    // One phase runs at a random capacity between the extremes.
    phase_caps[6] = lfu_ct_pkg::CapW'($urandom_range(3, 15));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table.
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == RowCfg) begin
        settle();
        write_capacity(dir_rows[r].value[lfu_ct_pkg::CapW-1:0]);
      end else begin
        it.func         = dir_rows[r].func;
        it.key          = dir_rows[r].key;
        it.value        = dir_rows[r].value;
        want.hit        = dir_rows[r].hit;
        want.read_value = dir_rows[r].rv;
        offer(it, pick_gap(), dir_rows[r].typed, want);
      end
    end

    // Random phases, each after a capacity write.
    for (int p = 0; p < 8; p++) begin
      settle();
      write_capacity(phase_caps[p]);
      run_random(phase_items[p], (p == 0) ? 100 : -1);
    end

    // Let the last results come out, then leave room for a stray one.
    drop_valid();
    while (lookup_results_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Result sink. Before each output transfer it stalls for a random number
  // of cycles, or for the long stretch that the stimulus asked for. Output
  // transfers are taken at the rising edge with stall low and valid high.
  initial begin : result_sink
    int                      wait_cycles;
    lfu_ct_pkg::lfu_ct_out_t want;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (sink_hold_cycles > 0) begin
        wait_cycles      = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        wait_cycles = pick_gap();
      end
      if (wait_cycles > 0) begin
        out_stall = 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      if (lookup_results_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with none owed: expected none, actual hit=%0b read_value=%0h",
                 $time, out_data.hit, out_data.read_value);
      end else begin
        want = lookup_results_q.pop_front();
        if (out_data.hit !== want.hit) begin
          mismatches++;
          $display("%0t: hit mismatch: expected %0b, actual %0b",
                   $time, want.hit, out_data.hit);
        end
        if (out_data.read_value !== want.read_value) begin
          mismatches++;
          $display("%0t: read_value mismatch: expected %0h, actual %0h",
                   $time, want.read_value, out_data.read_value);
        end
      end
    end
  end

  // Watchdog for a hung block.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout with %0d results owed", $time, lookup_results_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
